@@ rtl/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and codes for the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam logic [3:0] MAX_DIM     = 4'd8;
	localparam int         STORE_DEPTH = 64;
	localparam int         ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_MUL    = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic clear;
	} mac_ctl_t;

endpackage

@@ rtl/mme_mac.sv @@
// ----------------------------------------------------------------------------
// mme_mac
// Two-stage signed multiply-accumulate: 32x32 product register, then a
// 64-bit accumulator that saturates after every addition.
// ----------------------------------------------------------------------------
module mme_mac
	import mme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] acc,
	output logic               busy
);

	logic signed [63:0] prod_s2;
	logic               valid_s2;
	logic signed [63:0] acc_q;
	logic signed [63:0] sum;
	logic               ovf;
	logic signed [63:0] acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prod_s2 <= a * b;
		end
	end

	always_comb begin
		sum = acc_q + prod_s2;
		ovf = (acc_q[63] == prod_s2[63]) && (sum[63] != acc_q[63]);
		if (ovf) begin
			acc_d = prod_s2[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_d = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_d;
		end
	end

	assign acc  = acc_q;
	assign busy = valid_s2;

endmodule

@@ rtl/matrix_multiply_engine_core.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Loads two Q16.16 matrices into on-chip stores and emits their Q32.32
// product, one element per result word, in row-major order.
// ----------------------------------------------------------------------------
// A command word is taken into a one-word holding register, so the port takes
// a new word while the previous one is being worked on or its result waits on
// the output register. A load finishes once the output register is free. A
// multiply has a start step and then, per product element, an inner loop
// (skipped when a_cols is 0) that reads one element of each store per cycle
// from synchronous-read memories and feeds a two-stage multiply-accumulate,
// whose pipeline drains before the element is written to the output register.
// Mismatch and empty products give one result word. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core
	import mme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// command channel
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         op,
	input  logic [2:0]         row,
	input  logic [2:0]         col,
	input  logic signed [31:0] value,
	// result channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [2:0]         out_row,
	output logic [2:0]         out_col,
	output logic signed [63:0] product,
	output logic               last
);

	// configuration registers
	logic [3:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [3:0] ar, ac, br, bc;

	// holding register
	logic               pend_valid_q;
	logic [1:0]         pend_op_q;
	logic [2:0]         pend_row_q;
	logic [2:0]         pend_col_q;
	logic signed [31:0] pend_value_q;

	// output register
	logic               rsp_valid_q;
	logic [1:0]         status_q;
	logic [2:0]         out_row_q, out_col_q;
	logic signed [63:0] product_q;
	logic               last_q;

	// stores
	logic signed [31:0] mem_a [STORE_DEPTH];
	logic signed [31:0] mem_b [STORE_DEPTH];
	logic signed [31:0] rdata_a_s1, rdata_b_s1;
	logic               rd_valid_s1;

	// sequencer
	state_t     state_q, state_d;
	logic [2:0] i_q, j_q, k_q;
	logic       pend_take, wr_a, wr_b, issue, start, adv;
	logic       out_load, out_free;
	logic [1:0] out_status;
	logic [2:0] out_r, out_c;
	logic signed [63:0] out_p;
	logic       out_last;
	mac_ctl_t   mac_ctl;
	logic signed [63:0] mac_acc;
	logic       mac_busy;

	logic [3:0] ld_rows, ld_cols;
	logic [6:0] ld_idx, ld_lim;
	logic       ld_ok;
	logic [ADDR_W-1:0] ra, rb;
	logic       last_k, last_j, last_i, empty;

	function automatic logic [3:0] eff_dim(input logic [3:0] r);
		return (r > MAX_DIM) ? MAX_DIM : r;
	endfunction

	assign ar = eff_dim(a_rows_q);
	assign ac = eff_dim(a_cols_q);
	assign br = eff_dim(b_rows_q);
	assign bc = eff_dim(b_cols_q);

	// ---- configuration port ----
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= '0;
			a_cols_q <= '0;
			b_rows_q <= '0;
			b_cols_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_A_ROWS: a_rows_q <= pwdata[3:0];
				REG_A_COLS: a_cols_q <= pwdata[3:0];
				REG_B_ROWS: b_rows_q <= pwdata[3:0];
				REG_B_COLS: b_cols_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_A_ROWS: prdata = {28'd0, a_rows_q};
			REG_A_COLS: prdata = {28'd0, a_cols_q};
			REG_B_ROWS: prdata = {28'd0, b_rows_q};
			REG_B_COLS: prdata = {28'd0, b_cols_q};
			default:    prdata = '0;
		endcase
	end

	// ---- command holding register ----
	assign cmd_stall = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd_valid && !pend_valid_q) begin
			pend_valid_q <= 1'b1;
		end else if (pend_take) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !pend_valid_q) begin
			pend_op_q    <= op;
			pend_row_q   <= row;
			pend_col_q   <= col;
			pend_value_q <= value;
		end
	end

	// ---- load address and range check ----
	always_comb begin
		ld_rows = (pend_op_q == OP_LOAD_A) ? ar : br;
		ld_cols = (pend_op_q == OP_LOAD_A) ? ac : bc;
		ld_idx  = 7'(7'(pend_row_q) * 7'(ld_cols)) + 7'(pend_col_q);
		ld_lim  = 7'(7'(ld_rows) * 7'(ld_cols));
		ld_ok   = ld_idx < ld_lim;
	end

	// ---- multiply read addresses ----
	assign ra     = ADDR_W'(7'(7'(i_q) * 7'(ac)) + 7'(k_q));
	assign rb     = ADDR_W'(7'(7'(k_q) * 7'(bc)) + 7'(j_q));
	assign last_k = {1'b0, k_q} == ac - 4'd1;
	assign last_j = {1'b0, j_q} == bc - 4'd1;
	assign last_i = {1'b0, i_q} == ar - 4'd1;
	assign empty  = (ar == 4'd0) || (bc == 4'd0);

	assign out_free = !rsp_valid_q || !rsp_stall;

	// ---- stores ----
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[ld_idx[ADDR_W-1:0]] <= pend_value_q;
		end
		if (issue) begin
			rdata_a_s1 <= mem_a[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[ld_idx[ADDR_W-1:0]] <= pend_value_q;
		end
		if (issue) begin
			rdata_b_s1 <= mem_b[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		pend_take     = 1'b0;
		wr_a          = 1'b0;
		wr_b          = 1'b0;
		issue         = 1'b0;
		start         = 1'b0;
		adv           = 1'b0;
		out_load      = 1'b0;
		out_status    = STATUS_OK;
		out_r         = '0;
		out_c         = '0;
		out_p         = '0;
		out_last      = 1'b1;
		mac_ctl.valid = rd_valid_s1;
		mac_ctl.clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pend_valid_q && out_free) begin
					pend_take = 1'b1;
					case (pend_op_q)
						OP_LOAD_A, OP_LOAD_B: begin
							out_load   = 1'b1;
							out_status = ld_ok ? STATUS_OK : STATUS_RANGE;
							wr_a       = ld_ok && (pend_op_q == OP_LOAD_A);
							wr_b       = ld_ok && (pend_op_q == OP_LOAD_B);
						end
						OP_MUL: begin
							if (ac != br) begin
								out_load   = 1'b1;
								out_status = STATUS_MISMATCH;
							end else if (empty) begin
								out_load   = 1'b1;
								out_status = STATUS_EMPTY;
							end else begin
								start         = 1'b1;
								mac_ctl.clear = 1'b1;
								state_d       = (ac == 4'd0) ? ST_DRAIN : ST_MAC;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !mac_busy && out_free) begin
					out_load      = 1'b1;
					out_r         = i_q;
					out_c         = j_q;
					out_p         = mac_acc;
					out_last      = last_i && last_j;
					adv           = 1'b1;
					mac_ctl.clear = 1'b1;
					if (last_i && last_j) begin
						state_d = ST_IDLE;
					end else begin
						state_d = (ac == 4'd0) ? ST_DRAIN : ST_MAC;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else begin
				if (issue) begin
					k_q <= last_k ? 3'd0 : k_q + 3'd1;
				end
				if (adv) begin
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + 3'd1;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
			end
		end
	end

	mme_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (rdata_a_s1),
		.b      (rdata_b_s1),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= out_status;
			out_row_q <= out_r;
			out_col_q <= out_c;
			product_q <= out_p;
			last_q    <= out_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign last      = last_q;

endmodule
